@@ src/dpd_pkg.sv @@
// shared types, constants and tracker function for the presence debouncer
package dpd_pkg;

	localparam int CntBits = 8;
	localparam int CmpW = (CntBits > 8) ? CntBits : 8;
	localparam logic [CntBits-1:0] CntMax = {CntBits{1'b1}};

	localparam int QDepth = 2;
	localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW = $clog2(QDepth + 1);

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 8;

	localparam logic [7:0] RstThreshold = 8'd70;
	localparam logic [7:0] RstPersonClass = 8'd2;
	localparam logic [7:0] RstGlassesClass = 8'd1;
	localparam logic [7:0] RstFrames = 8'd5;

	typedef enum logic [CfgIdxW-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_PERSON_CLASS = 3'd1,
		REG_GLASSES_CLASS = 3'd2,
		REG_CONFIRM = 3'd3,
		REG_ABSENCE = 3'd4
	} cfg_idx_e;

	typedef struct packed {
		logic [7:0] score_threshold;
		logic [7:0] person_class;
		logic [7:0] glasses_class;
		logic [7:0] confirm_frames;
		logic [7:0] miss_limit;
	} cfg_t;

	typedef struct packed {
		logic box_valid;
		logic [7:0] class_id;
		logic [7:0] score;
		logic frame_last;
	} in_item_t;

	typedef struct packed {
		logic person_present;
		logic glasses_present;
		logic [7:0] person_best;
		logic [7:0] glasses_best;
		logic person_changed;
		logic glasses_changed;
	} out_item_t;

	// classified box as handed from front to back
	typedef struct packed {
		logic person_hit;
		logic glasses_hit;
		logic [7:0] score;
		logic last;
	} cls_item_t;

	typedef struct packed {
		logic present;
		logic [CntBits-1:0] hits;
		logic [CntBits-1:0] misses;
	} trk_t;

	function automatic logic [CntBits-1:0] sat_inc(input logic [CntBits-1:0] v);
		sat_inc = (v == CntMax) ? v : v + CntBits'(1);
	endfunction

	// one frame step of a present/absent tracker
	function automatic trk_t trk_advance(input trk_t cur, input logic detected,
		input logic [7:0] confirm, input logic [7:0] absence);
		trk_t nxt;
		nxt = cur;
		if (detected) begin
			nxt.misses = '0;
			nxt.hits = sat_inc(cur.hits);
			if (!cur.present && (CmpW'(nxt.hits) >= CmpW'(confirm)))
				nxt.present = 1'b1;
		end else begin
			nxt.hits = '0;
			if (cur.present) begin
				nxt.misses = sat_inc(cur.misses);
				if (CmpW'(nxt.misses) >= CmpW'(absence))
					nxt.present = 1'b0;
			end
		end
		trk_advance = nxt;
	endfunction

endpackage

@@ src/dpd_front.sv @@
// front end: takes boxes and classifies them against the watched classes
module dpd_front import dpd_pkg::*; (
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	input  cfg_t      cfg,
	input  logic      q_full,
	output logic      q_push,
	output cls_item_t q_item
);

	logic qualifies;

	assign qualifies = in_data.box_valid && (in_data.score >= cfg.score_threshold);

	always_comb begin
		q_item.person_hit = qualifies && (in_data.class_id == cfg.person_class);
		q_item.glasses_hit = qualifies && (in_data.class_id == cfg.glasses_class);
		q_item.score = in_data.score;
		q_item.last = in_data.frame_last;
	end

	assign in_stall = q_full;
	// boxes that touch no tracker are taken and dropped here
	assign q_push = in_valid && !q_full &&
		(q_item.last || q_item.person_hit || q_item.glasses_hit);

endmodule

@@ src/dpd_queue.sv @@
// short queue of classified boxes between front and back
module dpd_queue import dpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t din,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output cls_item_t dout
);

	cls_item_t mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
		ptr_next = (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
	endfunction

	assign full = (count_q == QCntW'(QDepth));
	assign not_empty = (count_q != '0);
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			case ({push, pop})
				2'b10: count_q <= count_q + QCntW'(1);
				2'b01: count_q <= count_q - QCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/dpd_back.sv @@
// back end: per-frame best scores, the two trackers and the result register
module dpd_back import dpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  cls_item_t q_item,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic person_seen_q, glasses_seen_q;
	logic [7:0] person_top_q, glasses_top_q;
	trk_t person_trk_q, glasses_trk_q;
	logic out_valid_q;
	out_item_t out_data_q;

	logic out_free;
	logic person_seen_n, glasses_seen_n;
	logic [7:0] person_top_n, glasses_top_n;
	trk_t person_trk_n, glasses_trk_n;

	assign out_free = !out_valid_q || !out_stall;
	// a frame end waits for a free result slot, plain boxes never wait
	assign q_pop = q_valid && (!q_item.last || out_free);

	always_comb begin
		person_seen_n = person_seen_q | q_item.person_hit;
		glasses_seen_n = glasses_seen_q | q_item.glasses_hit;
		person_top_n = (q_item.person_hit && (q_item.score > person_top_q)) ?
			q_item.score : person_top_q;
		glasses_top_n = (q_item.glasses_hit && (q_item.score > glasses_top_q)) ?
			q_item.score : glasses_top_q;
		person_trk_n = trk_advance(person_trk_q, person_seen_n,
			cfg.confirm_frames, cfg.miss_limit);
		glasses_trk_n = trk_advance(glasses_trk_q, glasses_seen_n,
			cfg.confirm_frames, cfg.miss_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			person_seen_q <= 1'b0;
			glasses_seen_q <= 1'b0;
			person_top_q <= '0;
			glasses_top_q <= '0;
			person_trk_q <= '0;
			glasses_trk_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.last) begin
					person_seen_q <= 1'b0;
					glasses_seen_q <= 1'b0;
					person_top_q <= '0;
					glasses_top_q <= '0;
					person_trk_q <= person_trk_n;
					glasses_trk_q <= glasses_trk_n;
				end else begin
					person_seen_q <= person_seen_n;
					glasses_seen_q <= glasses_seen_n;
					person_top_q <= person_top_n;
					glasses_top_q <= glasses_top_n;
				end
			end
			if (q_pop && q_item.last)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			out_data_q.person_present <= person_trk_n.present;
			out_data_q.glasses_present <= glasses_trk_n.present;
			out_data_q.person_best <= person_top_n;
			out_data_q.glasses_best <= glasses_top_n;
			out_data_q.person_changed <= person_trk_n.present ^ person_trk_q.present;
			out_data_q.glasses_changed <= glasses_trk_n.present ^ glasses_trk_q.present;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

@@ src/detection_presence_debouncer.sv @@
// top level of the presence debouncer: configuration registers and wiring
//
//   port group   dir   handshake               payload
//   in           in    in_valid / in_stall      in_data (box_valid, class_id, score, frame_last)
//   out          out   out_valid / out_stall    out_data (present, best, changed per class)
//   cfg          in    cfg_we                   cfg_index, cfg_wdata
//
// one box per cycle unless the queue is full; boxes reach the back end via a two-entry queue
// a frame result is valid the cycle after its frame-end transaction leaves the queue;
// on its way from the input that transaction passes a queue entry and then the result register
// the result register frees on the same cycle it is taken, so frames can close back to back
// reset clears trackers, per-frame scores, queue and result valid, and loads default config
// a stalled result holds frame ends in the queue; boxes keep flowing until the queue fills
module detection_presence_debouncer import dpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic q_full, q_push, q_pop, q_valid;
	cls_item_t push_item, head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= RstThreshold;
			cfg_q.person_class <= RstPersonClass;
			cfg_q.glasses_class <= RstGlassesClass;
			cfg_q.confirm_frames <= RstFrames;
			cfg_q.miss_limit <= RstFrames;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.score_threshold <= cfg_wdata;
				REG_PERSON_CLASS: cfg_q.person_class <= cfg_wdata;
				REG_GLASSES_CLASS: cfg_q.glasses_class <= cfg_wdata;
				REG_CONFIRM: cfg_q.confirm_frames <= cfg_wdata;
				REG_ABSENCE: cfg_q.miss_limit <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	dpd_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	dpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.dout      (head_item)
	);

	dpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
